// File: rtl/zero_order_hold_resampler_defines.svh
// assertion macros used by the checker file
`ifndef ZERO_ORDER_HOLD_RESAMPLER_DEFINES_SVH
`define ZERO_ORDER_HOLD_RESAMPLER_DEFINES_SVH

// consequent must hold in the same cycle as the trigger
`define ZOHR_ASSERT_NOW(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the trigger
`define ZOHR_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/zohr_pkg.sv
// shared types and constants of the zero order hold resampler
`default_nettype none
package zohr_pkg;

   localparam int RAW_W    = 24;
   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 36;
   localparam int POS_W    = 37;
   localparam int FRAC_W   = 32;

   localparam logic [STEP_W-1:0] STEP_RESET = 36'd1558264778;

   localparam int MAX_RUN   = 64;
   localparam int RUN_CNT_W = $clog2(MAX_RUN);

   localparam int QUEUE_DEPTH = 2;

   // one held sample word between front, queue and back
   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] sample;
   } zohr_word_type;

endpackage
`default_nettype wire

// File: rtl/zohr_front.sv
// input stage: takes packed samples and truncates them to 16 bits
`default_nettype none
module zohr_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [zohr_pkg::RAW_W-1:0]  req_sample_bytes,
   output      zohr_pkg::zohr_word_type     push_word,
   input  wire logic                        push_ready
);
   import zohr_pkg::*;

   logic                hold_valid_ff, hold_valid_in;
   logic [SAMPLE_W-1:0] hold_sample_ff, hold_sample_in;
   logic                req_take;

   assign req_ready = !hold_valid_ff || push_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      hold_valid_in  = hold_valid_ff;
      hold_sample_in = hold_sample_ff;
      if (req_take) begin
         hold_valid_in  = 1'b1;
         // arithmetic shift by 8 of the sign extended sample keeps bits 23..8
         hold_sample_in = req_sample_bytes[RAW_W-1:RAW_W-SAMPLE_W];
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_sample_ff <= hold_sample_in;
   end

   assign push_word.valid  = hold_valid_ff;
   assign push_word.sample = hold_sample_ff;

endmodule
`default_nettype wire

// File: rtl/zohr_queue.sv
// short queue of held samples between front and back
`default_nettype none
module zohr_queue #(
   parameter int Depth = zohr_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire zohr_pkg::zohr_word_type push_word,
   output      logic                    push_ready,
   output      zohr_pkg::zohr_word_type pop_word,
   input  wire logic                    pop_ready
);
   import zohr_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   logic [SAMPLE_W-1:0] slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign do_push    = push_word.valid && push_ready;
   assign do_pop     = pop_word.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word.sample;
      end
   end

   assign pop_word.valid  = (count_ff != '0);
   assign pop_word.sample = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// File: rtl/zohr_back.sv
// run engine: phase accumulator and one output frame per cycle while the output is not stalled
`default_nettype none
module zohr_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire zohr_pkg::zohr_word_type       pop_word,
   output      logic                          pop_ready,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [zohr_pkg::STEP_W-1:0]   csr_phase_step,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic signed [zohr_pkg::SAMPLE_W-1:0] rsp_left_sample,
   output      logic signed [zohr_pkg::SAMPLE_W-1:0] rsp_right_sample,
   output      logic                          rsp_last_of_run
);
   import zohr_pkg::*;

   localparam logic [POS_W-1:0]     OneSample = POS_W'(1) << FRAC_W;
   localparam logic [RUN_CNT_W-1:0] LastCnt   = RUN_CNT_W'(MAX_RUN - 1);

   logic [STEP_W-1:0]    step_ff, step_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 busy_ff, busy_in;
   logic [RUN_CNT_W-1:0] count_ff, count_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                 out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]  out_sample_ff, out_sample_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_adv, do_pop, start_crossed, crossed, run_last;
   logic [POS_W-1:0]     run_sum;

   assign csr_ready     = 1'b1;
   assign out_adv       = !out_valid_ff || rsp_ready;
   assign pop_ready     = !busy_ff;
   assign do_pop        = pop_word.valid && !busy_ff;
   assign start_crossed = |pos_ff[POS_W-1:FRAC_W];
   assign run_sum       = pos_ff + {1'b0, step_ff};
   assign crossed       = |run_sum[POS_W-1:FRAC_W];
   assign run_last      = crossed || (count_ff == LastCnt);

   always_comb begin
      step_in       = csr_valid ? csr_phase_step : step_ff;
      pos_in        = pos_ff;
      busy_in       = busy_ff;
      count_in      = count_ff;
      sample_in     = sample_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;

      if (do_pop) begin
         sample_in = pop_word.sample;
         if (start_crossed) begin
            // no output position in this interval
            pos_in = pos_ff - OneSample;
         end else begin
            busy_in  = 1'b1;
            count_in = '0;
         end
      end

      if (busy_ff && out_adv) begin
         out_valid_in  = 1'b1;
         out_sample_in = sample_ff;
         out_last_in   = run_last;
         count_in      = count_ff + 1'b1;
         if (run_last) begin
            busy_in = 1'b0;
            // run cap without crossing saturates the position at zero
            pos_in  = crossed ? (run_sum - OneSample) : '0;
         end else begin
            pos_in = run_sum;
         end
      end else if (out_adv) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         pos_ff       <= '0;
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      sample_ff     <= sample_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_sample  = $signed(out_sample_ff);
   assign rsp_right_sample = $signed(out_sample_ff);
   assign rsp_last_of_run  = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/zero_order_hold_resampler.sv
// top level of the zero order hold resampler: front, queue and run engine
// the first frame of an item passes the front hold register, a queue slot, the run sample and output registers
// the run engine takes no new word from the queue while a run of frames is going out
// the run engine emits at most one frame per cycle; front and queue keep taking words while the queue has room
// reset: synchronous, active high; clears queue, run state and phase position to zero
// reset also loads the phase step with 1558264778, about 16000/44100 in 4.32
`default_nettype none
module zero_order_hold_resampler #(
   parameter int QueueDepth = zohr_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input words: one packed 24-bit sample each
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [zohr_pkg::RAW_W-1:0]    req_sample_bytes,
   // phase step register write
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [zohr_pkg::STEP_W-1:0]   csr_phase_step,
   // output frames: left/right pair and end of run mark
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic signed [zohr_pkg::SAMPLE_W-1:0] rsp_left_sample,
   output      logic signed [zohr_pkg::SAMPLE_W-1:0] rsp_right_sample,
   output      logic                          rsp_last_of_run
);
   import zohr_pkg::*;

   // truncated sample from the front stage into the queue
   zohr_word_type push_word;
   logic          push_ready;
   // queue head toward the run engine
   zohr_word_type pop_word;
   logic          pop_ready;

   // front: holds one accepted word and keeps bits 23..8 of it
   zohr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_bytes (req_sample_bytes),
      .push_word        (push_word),
      .push_ready       (push_ready)
   );

   // queue: lets the front keep taking words while a run is going out
   zohr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   // back: phase accumulator walks the output positions in the interval,
   // one frame per cycle while the output is not stalled, into a registered output stage
   zohr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_word         (pop_word),
      .pop_ready        (pop_ready),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_phase_step   (csr_phase_step),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// File: rtl/zohr_checker.sv
// port level checks of the resampler and their bind
`default_nettype none
`include "zero_order_hold_resampler_defines.svh"
module zohr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [zohr_pkg::SAMPLE_W-1:0] rsp_left_sample,
   input wire logic signed [zohr_pkg::SAMPLE_W-1:0] rsp_right_sample,
   input wire logic                          rsp_last_of_run
);

   // both channels carry the same held sample
   `ZOHR_ASSERT_NOW(a_pair_equal, clock, reset, rsp_valid,
      rsp_left_sample == rsp_right_sample, "left and right words differ")

   // a stalled output word holds its fields
   `ZOHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_left_sample) && $stable(rsp_last_of_run),
      "stalled output word changed")

   // right after reset nothing is pending and input is open
   `ZOHR_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset),
      !rsp_valid && req_ready, "block not quiet after reset")

endmodule

bind zero_order_hold_resampler zohr_checker u_checker (.*);
`default_nettype wire
